>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared payload types, command records and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One block of work for the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_cmd_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [7:0]  ByteMask   = 8'hFF;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs bytes into 512-bit blocks, counts length, builds padding blocks.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha_pkg::in_item_t in_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output sha_pkg::blk_cmd_t cmd_o,
  input  logic              cmd_ready_i
);

  typedef enum logic [2:0] {
    FS_TAKE = 3'b001,
    FS_PAD  = 3'b010,
    FS_LEN  = 3'b100
  } fstate_e;

  fstate_e      state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [63:0]  len_q, len_d;
  logic         cv_q, cv_d;
  sha_pkg::blk_cmd_t cmd_q, cmd_d;

  logic         acc;
  logic         slot_free;
  logic [511:0] padded;
  logic [63:0]  bits;

  assign slot_free = !cv_q || cmd_ready_i;
  assign full_o    = !(state_q == FS_TAKE) || !slot_free;
  assign acc       = push_i && !full_o;
  assign bits      = {len_q[60:0], 3'b000};

  // Buffer with pad byte at cnt and zeros after it.
  always_comb begin
    padded = buf_q;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == cnt_q) padded[511-8*i -: 8] = sha_pkg::PadByte;
      else if (6'(i) > cnt_q) padded[511-8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    cv_d    = cv_q && !cmd_ready_i;
    cmd_d   = cmd_q;
    case (state_q)
      FS_TAKE: begin
        if (acc) begin
          if (in_i.byte_valid) begin
            buf_d[511-8*cnt_q -: 8] = in_i.data_byte & sha_pkg::ByteMask;
            cnt_d = cnt_q + 6'd1;
            len_d = len_q + 64'd1;
            if (cnt_q == 6'(sha_pkg::BlockBytes - 1)) begin
              cv_d  = 1'b1;
              cmd_d = '{block: buf_d, final_blk: 1'b0};
            end
          end
          if (in_i.end_of_message) state_d = FS_PAD;
        end
      end
      FS_PAD: begin
        if (slot_free) begin
          cv_d = 1'b1;
          if (cnt_q >= 6'(sha_pkg::LenPos)) begin
            // Padding spills: emit data-and-pad block, length goes in next.
            cmd_d   = '{block: padded, final_blk: 1'b0};
            state_d = FS_LEN;
          end else begin
            cmd_d = '{block: {padded[511:64], bits}, final_blk: 1'b1};
            state_d = FS_TAKE;
            cnt_d = '0;
            len_d = '0;
          end
        end
      end
      FS_LEN: begin
        if (slot_free) begin
          cv_d    = 1'b1;
          cmd_d   = '{block: {448'd0, bits}, final_blk: 1'b1};
          state_d = FS_TAKE;
          cnt_d   = '0;
          len_d   = '0;
        end
      end
      default: state_d = FS_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_TAKE;
      cnt_q   <= '0;
      len_q   <= '0;
      cv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cv_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// One round per cycle, rolling 16-word schedule, digest words read out by index.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  sha_pkg::blk_cmd_t  cmd_i,
  output logic               cmd_ready_o,
  output logic               empty_o,
  output sha_pkg::out_item_t out_o,
  input  logic               pop_i
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_OUT   = 3'b100
  } cstate_e;

  cstate_e      state_q, state_d;
  logic [255:0] h_q, h_d;
  logic [255:0] v_q, v_d;
  logic [511:0] w_q, w_d;
  logic [5:0]   t_q, t_d;
  logic [2:0]   idx_q, idx_d;
  logic         fin_q, fin_d;

  logic [31:0] a, b, c, d, e, f, g, hh, wt, w1, w14, w9;
  logic [31:0] s0, s1, e1, a0, ch, maj, t1, t2, wn;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign {a, b, c, d, e, f, g, hh} = v_q;
  assign wt  = w_q[511:480];
  assign w1  = w_q[479:448];
  assign w9  = w_q[223:192];
  assign w14 = w_q[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wn  = wt + s0 + w9 + s1;
  assign e1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign ch  = (e & f) ^ (~e & g);
  assign t1  = hh + e1 + ch + sha_pkg::round_k(t_q) + wt;
  assign a0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t2  = a0 + maj;

  assign cmd_ready_o = (state_q == CS_IDLE);
  assign empty_o     = !(state_q == CS_OUT);
  assign out_o.digest_word = h_q[255-32*idx_q -: 32];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    h_d = h_q; v_d = v_q; w_d = w_q;
    t_d = t_q; idx_d = idx_q; fin_d = fin_q;
    case (state_q)
      CS_IDLE: begin
        if (cmd_valid_i) begin
          v_d = h_q; w_d = cmd_i.block; fin_d = cmd_i.final_blk;
          t_d = '0; state_d = CS_ROUND;
        end
      end
      CS_ROUND: begin
        v_d = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_d = {w_q[479:0], wn};
        t_d = t_q + 6'd1;
        if (t_q == 6'd63) begin
          // Final round: fold the updated working words into the hash.
          for (int i = 0; i < 8; i++) h_d[32*i +: 32] = h_q[32*i +: 32] + v_d[32*i +: 32];
          idx_d   = '0;
          state_d = fin_q ? CS_OUT : CS_IDLE;
        end
      end
      CS_OUT: begin
        if (pop_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            h_d = sha_pkg::InitHash;
            state_d = CS_IDLE;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      h_q     <= sha_pkg::InitHash;
      t_q     <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      t_q     <= t_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Byte-at-a-time SHA-256 with padding and digest word output.
// ----------------------------------------------------------------------------
// Input channel: push / full, at most one byte (optionally with an end flag)
// per accepted request. Output channel: empty / pop, eight digest words per
// message, index 0 first, last_word set on index 7.
// The front end packs bytes into a block register and hands full blocks to a
// one-entry command register; the engine loads each block and then runs one
// round per cycle. Bytes keep flowing while a block compresses until the next
// block is full, so the sustained rate is bound by the round loop.
// End of message: one or two padding blocks (two when 56 or more bytes are
// buffered), then the eight words wait in the engine.
// A stalled receiver holds the engine; the front end keeps filling the
// next block and then raises full_o.
// Reset loads the initial hash values and clears counts; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sha_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::out_item_t out_item_o
);

  logic              cmd_valid, cmd_ready;
  sha_pkg::blk_cmd_t cmd;

  sha_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .in_i(in_item_i), .full_o(full),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .empty_o(empty), .out_o(out_item_o), .pop_i(pop)
  );

`ifndef ASSERT_OFF
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_word == (out_item_o.word_index == 3'd7)))
    else $error("last_word mismatch");
  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last_word) |=>
      (!empty && out_item_o.word_index == $past(out_item_o.word_index) + 3'd1))
    else $error("index did not advance");
`endif

endmodule
